@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// shared types for the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int CSR_BITS = 7;

   typedef struct packed {
      logic load;
      logic shift;
      logic flush;
   } swm_ctrl_type;

endpackage

@@ rtl/swm_if.sv @@
// ----------------------------------------------------------------------------
// swm_req_if / swm_rsp_if / swm_csr_if
// valid/ready channels for samples, results and the window size register
// ----------------------------------------------------------------------------
interface swm_req_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_in_set;
   modport source (output valid, output sample, output last_in_set, input ready);
   modport sink (input valid, input sample, input last_in_set, output ready);
endinterface

interface swm_rsp_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;
   logic                          last_result;
   modport source (output valid, output window_max, output last_result, input ready);
   modport sink (input valid, input window_max, input last_result, output ready);
endinterface

interface swm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [swm_pkg::CSR_BITS-1:0]   window_size;
   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the candidate queue; shifts toward the front, drops entries
// not greater than the new sample and takes the sample at the queue tail
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int POS_W       = 7,
   parameter int POS_MOD     = 128,
   parameter int EFF_W       = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::swm_ctrl_type         ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [POS_W-1:0]              pos,
   input  logic [EFF_W-1:0]              eff,
   input  logic                          nxt_valid,
   input  logic signed [SAMPLE_BITS-1:0] nxt_value,
   input  logic [POS_W-1:0]              nxt_pos,
   input  logic                          prv_keep,
   output logic                          cur_valid,
   output logic signed [SAMPLE_BITS-1:0] cur_value,
   output logic [POS_W-1:0]              cur_pos,
   output logic signed [SAMPLE_BITS-1:0] value_next,
   output logic                          keep,
   output logic                          expired
);
   import swm_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          src_valid;
   logic signed [SAMPLE_BITS-1:0] src_value;
   logic [POS_W-1:0]              src_pos;
   logic [POS_W:0]                age;

   assign src_valid = ctrl.shift ? nxt_valid : valid_ff;
   assign src_value = ctrl.shift ? nxt_value : value_ff;
   assign src_pos   = ctrl.shift ? nxt_pos   : pos_ff;
   assign keep      = src_valid && (src_value > sample);

   // age of the held candidate, modulo the position range
   always_comb begin
      if (pos >= pos_ff) begin
         age = {1'b0, pos} - {1'b0, pos_ff};
      end else begin
         age = {1'b0, pos} + (POS_W+1)'(POS_MOD) - {1'b0, pos_ff};
      end
   end

   assign expired = valid_ff && (age >= (POS_W+1)'(eff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      if (ctrl.load) begin
         if (keep) begin
            valid_in = 1'b1;
            value_in = src_value;
            pos_in   = src_pos;
         end else if (prv_keep) begin
            valid_in = 1'b1;
            value_in = sample;
            pos_in   = pos;
         end else begin
            valid_in = 1'b0;
         end
      end else if (ctrl.shift) begin
         valid_in = nxt_valid;
         value_in = nxt_value;
         pos_in   = nxt_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.flush) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign cur_valid  = valid_ff;
   assign cur_value  = value_ff;
   assign cur_pos    = pos_ff;
   assign value_next = value_in;

endmodule

@@ rtl/sliding_window_maximum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_maximum
// running maximum over the last window_size signed samples of a set
// ----------------------------------------------------------------------------
// req_if carries one sample per transaction, with last_in_set on the final
// sample of a set. once window_size samples of the set have been taken, each
// transaction gives one rsp_if transaction holding the window maximum and a
// copy of last_in_set. csr_if writes window_size (0 gives no results; values
// above WINDOW_MAX act as WINDOW_MAX); it is always ready.
// candidates live in a row of WINDOW_MAX cells, oldest at cell 0; every
// cell compares against the new sample at once and the tail takes it.
// the result is registered, in the cycle after the sample transaction.
// throughput: one sample per cycle while no result waits or rsp_if.ready is
// high; after a window_size change mid-set, samples wait while the two front
// candidates have both expired, since the row shifts one cell per cycle.
// a stalled result holds in the output register; one new sample is still
// taken while it waits only if rsp_if.ready is high in that cycle.
// reset clears the queue, the sample count and the write position and sets
// window_size to 1; the end of a set clears the same state except the register.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   swm_req_if.sink  req_if,
   swm_rsp_if.source rsp_if,
   swm_csr_if.sink  csr_if
);
   import swm_pkg::*;

   localparam int POS_MOD = 2 * WINDOW_MAX;
   localparam int POS_W   = $clog2(POS_MOD);
   localparam int EFF_W   = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W   = EFF_W > CSR_BITS ? EFF_W : CSR_BITS;

   logic [CSR_BITS-1:0]           window_size_ff;
   logic [POS_W-1:0]              write_pos_ff, write_pos_in;
   logic [POS_W-1:0]              seen_ff, seen_in;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] window_max_ff;
   logic                          last_result_ff;

   logic [EFF_W-1:0]              eff;
   logic                          room;
   logic                          double_exp;
   logic                          accept;
   logic                          produce;
   swm_ctrl_type                  ctrl;

   logic                          c_valid [0:WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] c_value [0:WINDOW_MAX];
   logic [POS_W-1:0]              c_pos   [0:WINDOW_MAX];
   logic                          c_exp   [0:WINDOW_MAX];
   logic                          c_keep  [0:WINDOW_MAX-1];
   logic signed [SAMPLE_BITS-1:0] c_next  [0:WINDOW_MAX-1];
   logic [WINDOW_MAX-1:0]         valid_vec;

   assign c_valid[WINDOW_MAX] = 1'b0;
   assign c_value[WINDOW_MAX] = '0;
   assign c_pos[WINDOW_MAX]   = '0;
   assign c_exp[WINDOW_MAX]   = 1'b0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .POS_W       (POS_W),
         .POS_MOD     (POS_MOD),
         .EFF_W       (EFF_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sample     (req_if.sample),
         .pos        (write_pos_ff),
         .eff        (eff),
         .nxt_valid  (c_valid[i+1]),
         .nxt_value  (c_value[i+1]),
         .nxt_pos    (c_pos[i+1]),
         .prv_keep   ((i == 0) ? 1'b1 : c_keep[(i == 0) ? 0 : i-1]),
         .cur_valid  (c_valid[i]),
         .cur_value  (c_value[i]),
         .cur_pos    (c_pos[i]),
         .value_next (c_next[i]),
         .keep       (c_keep[i]),
         .expired    (c_exp[i])
      );
      assign valid_vec[i] = c_valid[i];
   end

   always_comb begin
      if (CMP_W'(window_size_ff) > CMP_W'(WINDOW_MAX)) begin
         eff = EFF_W'(WINDOW_MAX);
      end else begin
         eff = EFF_W'(window_size_ff);
      end
   end

   assign room       = !rsp_valid_ff || rsp_if.ready;
   assign double_exp = (eff != '0) && c_exp[0] && c_exp[1];
   assign req_if.ready = room && !double_exp;
   assign accept     = req_if.valid && req_if.ready;

   // extra front pops while more than one candidate has left the window
   assign ctrl.load  = accept && (eff != '0);
   assign ctrl.shift = (accept && (eff != '0)) ? c_exp[0] : (req_if.valid && double_exp);
   assign ctrl.flush = accept && ((eff == '0) || req_if.last_in_set);

   assign seen_in      = (seen_ff == POS_W'(POS_MOD - 1)) ? seen_ff : seen_ff + 1'b1;
   assign write_pos_in = (write_pos_ff == POS_W'(POS_MOD - 1)) ? '0 : write_pos_ff + 1'b1;
   assign produce      = ctrl.load && ((POS_W+1)'(seen_in) >= (POS_W+1)'(eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CSR_BITS'(1);
      end else if (csr_if.valid) begin
         window_size_ff <= csr_if.window_size;
      end
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         seen_ff      <= '0;
      end else if (accept) begin
         write_pos_ff <= req_if.last_in_set ? '0 : write_pos_in;
         seen_ff      <= req_if.last_in_set ? '0 : seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         window_max_ff  <= c_next[0];
         last_result_ff <= req_if.last_in_set;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.window_max  = window_max_ff;
   assign rsp_if.last_result = last_result_ff;

   // candidates always fill the row from the front
   assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("candidate row has a gap");

   // the front candidate is strictly greater than the one behind it
   assert property (@(posedge clock) disable iff (reset)
      c_valid[1] |-> (c_value[0] > c_value[1]))
      else $error("front candidate not the largest");

   // the end of a set leaves no candidates and no count behind
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.last_in_set) |=> (valid_vec == '0 && seen_ff == '0))
      else $error("set state not cleared");

endmodule
